[sv/dq_pkg.sv]
// shared types and constants for the double-ended queue
// operation and status codes, cell commands and controller states; no dependencies
package dq_pkg;

    localparam int DQ_CAPACITY = 64;
    localparam int DQ_DATA_W   = 32;
    localparam int DQ_OCC_W    = 7;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FWD   = 3'd4,
        OP_READ_BWD   = 3'd5,
        OP_COUNT      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_ROT_LEFT,
        CMD_ROT_RIGHT
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_TRAVERSE
    } state_t;

endpackage

[sv/dq_cell.sv]
// one storage cell of the deque row: an entry and its valid bit
// depends on dq_pkg for the cell command type
module dq_cell
    import dq_pkg::*;
#(
    parameter int DATA_W = DQ_DATA_W
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic                     prev_valid,
    input  logic signed [DATA_W-1:0] next_data,
    input  logic                     next_valid,
    input  logic signed [DATA_W-1:0] head_data,
    output logic signed [DATA_W-1:0] data,
    output logic                     valid,
    output logic signed [DATA_W-1:0] tail_tap
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     is_tail;

    assign is_tail = valid_reg && !next_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                data_next  = prev_data;
                valid_next = prev_valid;
            end
            CMD_PUSH_BACK:
            begin
                // first free cell takes the new entry
                if (!valid_reg && prev_valid)
                begin
                    data_next  = value;
                    valid_next = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            CMD_POP_BACK:
            begin
                if (is_tail)
                    valid_next = 1'b0;
            end
            CMD_ROT_LEFT:
            begin
                // the tail wraps round to take the head entry
                if (valid_reg)
                    data_next = next_valid ? next_data : head_data;
            end
            CMD_ROT_RIGHT:
            begin
                if (valid_reg)
                    data_next = prev_data;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    assign tail_tap = is_tail ? data_reg : '0;

endmodule

[sv/double_ended_queue.sv]
// top level of the bounded double-ended queue: controller and a row of cells
// depends on dq_pkg and dq_cell
//
// The deque is held in a row of cells, the front entry in the first cell.
// Pushes, pops and count queries leave busy low, so the next command may
// follow in the next cycle. A forward or backward read of N entries
// rotates the row one place per cycle and keeps busy high until all N
// entries are out, giving one result beat per cycle; the row is back in its
// original order when the read ends. Every result is registered and appears
// on the outputs in the cycle after the cycle that produced it, is marked by
// strobe for exactly one cycle and cannot be held off by the receiver.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int CAPACITY = DQ_CAPACITY
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  operation,
    input  logic signed [DQ_DATA_W-1:0] value,
    output logic                        strobe,
    output logic [1:0]                  status,
    output logic signed [DQ_DATA_W-1:0] item,
    output logic                        last,
    output logic [DQ_OCC_W-1:0]         occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                    state_reg;
    state_t                    state_next;
    logic                      dir_reg;
    logic                      dir_next;
    logic [CNT_W-1:0]          remain_reg;
    logic [CNT_W-1:0]          remain_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      strobe_reg;
    logic                      strobe_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [DQ_DATA_W-1:0] item_reg;
    logic signed [DQ_DATA_W-1:0] item_next;
    logic                      last_reg;
    logic                      last_next;
    logic [CNT_W-1:0]          occ_reg;
    logic [CNT_W-1:0]          occ_next;

    logic                      accept;
    logic                      is_full;
    logic                      is_empty;
    logic                      is_read;
    cmd_t                      cmd;

    logic signed [DQ_DATA_W-1:0] cell_data [CAPACITY];
    logic                        cell_valid [CAPACITY];
    logic signed [DQ_DATA_W-1:0] cell_tap [CAPACITY];
    logic signed [DQ_DATA_W-1:0] tail_bus;
    logic signed [DQ_DATA_W-1:0] head_data;
    logic signed [DQ_DATA_W-1:0] first_prev;

    assign busy     = (state_reg == ST_TRAVERSE);
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign is_read  = (op_t'(operation) == OP_READ_FWD) || (op_t'(operation) == OP_READ_BWD);

    // at most one cell, the tail, drives its entry onto the tail bus (none when empty)
    always_comb
    begin
        tail_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
            tail_bus = tail_bus | cell_tap[i];
    end

    assign head_data  = cell_data[0];
    assign first_prev = (cmd == CMD_PUSH_FRONT) ? value : tail_bus;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_read && !is_empty)
                    state_next = ST_TRAVERSE;
            end
            ST_TRAVERSE:
            begin
                if (remain_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // cell commands, counters and result beat
    always_comb
    begin
        cmd         = CMD_HOLD;
        count_next  = count_reg;
        dir_next    = dir_reg;
        remain_next = remain_reg;
        strobe_next = 1'b0;
        status_next = STAT_OK;
        item_next   = '0;
        last_next   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (op_t'(operation))
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                                status_next = STAT_FULL;
                            else
                            begin
                                cmd        = CMD_PUSH_FRONT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                                status_next = STAT_FULL;
                            else
                            begin
                                cmd        = CMD_PUSH_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                cmd        = CMD_POP_FRONT;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                cmd        = CMD_POP_BACK;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_READ_FWD, OP_READ_BWD:
                        begin
                            if (is_empty)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                // beats come from the traversal cycles
                                strobe_next = 1'b0;
                                remain_next = count_reg;
                                dir_next    = (op_t'(operation) == OP_READ_BWD);
                            end
                        end
                        default:
                            status_next = STAT_OK;
                    endcase
                end
            end
            ST_TRAVERSE:
            begin
                cmd         = dir_reg ? CMD_ROT_RIGHT : CMD_ROT_LEFT;
                strobe_next = 1'b1;
                item_next   = dir_reg ? tail_bus : head_data;
                last_next   = (remain_reg == CNT_W'(1));
                remain_next = remain_reg - CNT_W'(1);
            end
            default:
                cmd = CMD_HOLD;
        endcase
        occ_next = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dir_reg    <= 1'b0;
            remain_reg <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dir_reg    <= dir_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        last_reg   <= last_next;
        occ_reg    <= occ_next;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DQ_DATA_W-1:0] prev_d;
            logic                        prev_v;
            logic signed [DQ_DATA_W-1:0] next_d;
            logic                        next_v;

            if (g == 0)
            begin : g_first
                assign prev_d = first_prev;
                assign prev_v = 1'b1;
            end
            else
            begin : g_inner_prev
                assign prev_d = cell_data[g-1];
                assign prev_v = cell_valid[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign next_d = '0;
                assign next_v = 1'b0;
            end
            else
            begin : g_inner_next
                assign next_d = cell_data[g+1];
                assign next_v = cell_valid[g+1];
            end

            dq_cell #(
                .DATA_W (DQ_DATA_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .value      (value),
                .prev_data  (prev_d),
                .prev_valid (prev_v),
                .next_data  (next_d),
                .next_valid (next_v),
                .head_data  (head_data),
                .data       (cell_data[g]),
                .valid      (cell_valid[g]),
                .tail_tap   (cell_tap[g])
            );
        end
    endgenerate

    assign strobe    = strobe_reg;
    assign status    = 2'(status_reg);
    assign item      = item_reg;
    assign last      = last_reg;
    assign occupancy = DQ_OCC_W'(occ_reg);

endmodule
